// ===== design/best_fit_normal_scale_search_unit_defines.svh =====
// Assertion macros used by the search unit design file.
`ifndef BEST_FIT_NORMAL_SCALE_SEARCH_UNIT_DEFINES_SVH
`define BEST_FIT_NORMAL_SCALE_SEARCH_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define BFNS_ASSERT_IMPL(label, clk, rst, pre, con) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (con)) \
    else $error("assertion failed");
`define BFNS_ASSERT_NEXT(label, clk, rst, pre, con) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (con)) \
    else $error("assertion failed");
`else
`define BFNS_ASSERT_IMPL(label, clk, rst, pre, con)
`define BFNS_ASSERT_NEXT(label, clk, rst, pre, con)
`endif
`endif

// ===== design/bfns_pkg.sv =====
package bfns_pkg;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int GRID_W     = 11;
  localparam int SCALE_W    = 8;
  localparam int ADDR_W     = 20;
  localparam int S_DATA_W   = 24;
  localparam int M_DATA_W   = 32;
  localparam int FRAC_W     = 24;
  localparam int NORM_W     = 25;
  localparam int SQ_W       = 22;
  localparam int NUMY_W     = 22;
  localparam int REMX_W     = 13;
  localparam int REMY_W     = 24;
  localparam int DIV_STEPS  = 24;
  localparam int NUM_SCALES = 127;

  localparam logic [GRID_W-1:0] GRID_RESET = 11'd1024;
  localparam logic [NORM_W-1:0] ONE_Q24    = 25'h100_0000;

  typedef struct packed {
    logic [REMX_W-1:0] rem_x;
    logic [FRAC_W-1:0] q_x;
    logic [REMY_W-1:0] rem_y;
    logic [FRAC_W-1:0] q_y;
    logic [GRID_W-1:0] d;
    logic [SQ_W-1:0]   dsq;
    logic              sat_x;
    logic              sat_y;
    logic [ADDR_W-1:0] addr;
  } div_stage_t;

  typedef struct packed {
    logic [NORM_W-1:0]  pm_x;
    logic [NORM_W-1:0]  pm_y;
    logic [NORM_W-1:0]  two_x;
    logic [NORM_W-1:0]  two_y;
    logic [SCALE_W-1:0] best_m;
    logic [NORM_W-1:0]  best_e;
    logic [ADDR_W-1:0]  addr;
  } srch_stage_t;

  // Distance of the fractional product from one half step, in Q24.
  function automatic logic [NORM_W-1:0] comp_err(input logic [NORM_W-1:0] pm);
    logic [NORM_W-1:0] e;
    if (pm[NORM_W-1]) begin
      e = {1'b0, pm[NORM_W-2:0]};
    end else begin
      e = ONE_Q24 - pm;
    end
    return e;
  endfunction

endpackage

// ===== design/best_fit_normal_scale_search_unit.sv =====
// Channel  Dir  Width  Contents
// cfg      in   11     grid_size
// s        in   24     column, row
// m        out  32     scale_byte, table_address
//
// One transfer is accepted every cycle while the output register is empty or taken;
// each result passes through 153 register stages: one setup stage, 24 divider
// steps, one normal stage, 127 scale cells.
// The pipeline advances as a whole whenever the output register is empty or taken.
// Reset clears all valid bits and sets grid_size to 1024.
`include "best_fit_normal_scale_search_unit_defines.svh"
module best_fit_normal_scale_search_unit #(
  parameter int MAX_GRID = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bfns_pkg::GRID_W-1:0]      cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // column [9:0], row [19:10]
  input  logic [bfns_pkg::S_DATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // scale_byte [7:0], table_address [27:8]
  output logic [bfns_pkg::M_DATA_W-1:0]    m_tdata
);
  import bfns_pkg::*;

  logic [GRID_W-1:0] grid_size;
  logic              en;

  div_stage_t  dv [0:DIV_STEPS];
  logic        dv_valid [0:DIV_STEPS];
  srch_stage_t sr [0:NUM_SCALES];
  logic        sv [0:NUM_SCALES];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_RESET;
    end else if (cfg_we) begin
      grid_size <= cfg_wdata;
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Setup stage.
  logic [COL_W-1:0]    column;
  logic [ROW_W-1:0]    row;
  logic [GRID_W-1:0]   d;
  logic [GRID_W-1:0]   num_x;
  logic [SQ_W-1:0]     dsq;
  logic [NUMY_W-1:0]   num_y;
  logic [ADDR_W:0]     rd;
  div_stage_t          dv0_next;

  assign column = s_tdata[COL_W-1:0];
  assign row    = s_tdata[COL_W+ROW_W-1:COL_W];

  always_comb begin
    if (grid_size == '0) begin
      d = GRID_W'(1);
    end else if (int'(grid_size) > MAX_GRID) begin
      d = GRID_W'(MAX_GRID);
    end else begin
      d = grid_size;
    end
    num_x = {column, 1'b1};
    dsq   = SQ_W'(d) * SQ_W'(d);
    num_y = NUMY_W'({row, 1'b1}) * NUMY_W'(GRID_W'(column) + GRID_W'(1));
    rd    = (ADDR_W+1)'(row) * (ADDR_W+1)'(d);
    dv0_next.rem_x = REMX_W'(num_x);
    dv0_next.q_x   = '0;
    dv0_next.rem_y = REMY_W'(num_y);
    dv0_next.q_y   = '0;
    dv0_next.d     = d;
    dv0_next.dsq   = dsq;
    dv0_next.sat_x = {1'b0, num_x} >= {d, 1'b0};
    dv0_next.sat_y = {1'b0, num_y} >= {dsq, 1'b0};
    dv0_next.addr  = rd[ADDR_W-1:0] + ADDR_W'(column);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= dv0_next;
    end
  end

  // Restoring division, one quotient bit of each normal component per stage.
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    localparam int BIT = DIV_STEPS - k;
    logic [FRAC_W-1:0] low_x;
    logic [FRAC_W-1:0] low_y;
    logic [REMX_W-1:0] rx;
    logic [REMY_W-1:0] ry;
    div_stage_t        nxt;

    always_comb begin
      low_x = FRAC_W'(dv[k-1].d);
      low_y = FRAC_W'(dv[k-1].dsq);
      nxt   = dv[k-1];
      rx    = {dv[k-1].rem_x[REMX_W-2:0], low_x[BIT]};
      ry    = {dv[k-1].rem_y[REMY_W-2:0], low_y[BIT]};
      if (rx >= REMX_W'({dv[k-1].d, 1'b0})) begin
        nxt.rem_x = rx - REMX_W'({dv[k-1].d, 1'b0});
        nxt.q_x   = {dv[k-1].q_x[FRAC_W-2:0], 1'b1};
      end else begin
        nxt.rem_x = rx;
        nxt.q_x   = {dv[k-1].q_x[FRAC_W-2:0], 1'b0};
      end
      if (ry >= REMY_W'({dv[k-1].dsq, 1'b0})) begin
        nxt.rem_y = ry - REMY_W'({dv[k-1].dsq, 1'b0});
        nxt.q_y   = {dv[k-1].q_y[FRAC_W-2:0], 1'b1};
      end else begin
        nxt.rem_y = ry;
        nxt.q_y   = {dv[k-1].q_y[FRAC_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k] <= 1'b0;
      end else if (en) begin
        dv_valid[k] <= dv_valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k] <= nxt;
      end
    end
  end

  // Normal stage: saturate and form the product with the first scale.
  logic [NORM_W-1:0] n_x;
  logic [NORM_W-1:0] n_y;
  srch_stage_t       sr0_next;

  always_comb begin
    n_x = dv[DIV_STEPS].sat_x ? ONE_Q24 : {1'b0, dv[DIV_STEPS].q_x};
    n_y = dv[DIV_STEPS].sat_y ? ONE_Q24 : {1'b0, dv[DIV_STEPS].q_y};
    sr0_next.two_x  = {n_x[NORM_W-2:0], 1'b0};
    sr0_next.two_y  = {n_y[NORM_W-2:0], 1'b0};
    sr0_next.pm_x   = n_x + {n_x[NORM_W-2:0], 1'b0};
    sr0_next.pm_y   = n_y + {n_y[NORM_W-2:0], 1'b0};
    sr0_next.best_m = '0;
    sr0_next.best_e = '0;
    sr0_next.addr   = dv[DIV_STEPS].addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= dv_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= sr0_next;
    end
  end

  // One cell per scale; each keeps the best scale seen so far.
  for (genvar j = 0; j < NUM_SCALES; j++) begin : g_scale
    localparam logic [SCALE_W-1:0] M = SCALE_W'(2 * j + 3);
    logic [NORM_W-1:0]         ex;
    logic [NORM_W-1:0]         ey;
    logic [NORM_W-1:0]         e;
    logic [NORM_W+SCALE_W-1:0] lhs;
    logic [NORM_W+SCALE_W-1:0] rhs;
    logic                      better;
    srch_stage_t               nxt;

    always_comb begin
      ex     = comp_err(sr[j].pm_x);
      ey     = comp_err(sr[j].pm_y);
      e      = (ex > ey) ? ex : ey;
      lhs    = (NORM_W+SCALE_W)'(e) * (NORM_W+SCALE_W)'(sr[j].best_m);
      rhs    = (NORM_W+SCALE_W)'(sr[j].best_e) * (NORM_W+SCALE_W)'(M);
      better = (j == 0) || (lhs < rhs);
      nxt      = sr[j];
      nxt.pm_x = sr[j].pm_x + sr[j].two_x;
      nxt.pm_y = sr[j].pm_y + sr[j].two_y;
      if (better) begin
        nxt.best_m = M;
        nxt.best_e = e;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else if (en) begin
        sv[j+1] <= sv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr[j+1] <= nxt;
      end
    end
  end

  assign m_tvalid = sv[NUM_SCALES];
  assign m_tdata  = M_DATA_W'({sr[NUM_SCALES].addr, sr[NUM_SCALES].best_m});

  `BFNS_ASSERT_IMPL(a_scale_odd, clk, rst, m_tvalid, m_tdata[0] && (m_tdata[SCALE_W-1:0] != 8'd1))
  `BFNS_ASSERT_NEXT(a_accept_enters, clk, rst, s_tvalid && s_tready, dv_valid[0])
  `BFNS_ASSERT_IMPL(a_rem_below_div, clk, rst, dv_valid[DIV_STEPS] && !dv[DIV_STEPS].sat_x, dv[DIV_STEPS].rem_x < REMX_W'({dv[DIV_STEPS].d, 1'b0}))
  `BFNS_ASSERT_IMPL(a_first_scale, clk, rst, sv[1], sr[1].best_m == 8'd3)

endmodule

// ===== tb/tb_best_fit_normal_scale_search_unit.sv =====
module tb_best_fit_normal_scale_search_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bfns_pkg::*;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [ADDR_W-1:0] addr;
  } fit_t;

  class fit_board;
    fit_t pending[$];
    int unsigned errors;
    int unsigned checked;
    logic [GRID_W-1:0] grid;

    function void set_grid(logic [GRID_W-1:0] g);
      grid = g;
    endfunction

    static function longint unsigned dist_half(longint unsigned n, longint unsigned m);
      longint unsigned rem;
      rem = (n * m) & 64'h1FF_FFFF;
      return (rem >= 64'h100_0000) ? rem - 64'h100_0000 : 64'h100_0000 - rem;
    endfunction

    static function longint unsigned q24_ratio(longint unsigned num, longint unsigned den);
      longint unsigned v;
      v = (num * 64'h100_0000 + den / 2) / den;
      return (v > 64'h100_0000) ? 64'h100_0000 : v;
    endfunction

    function void note_cell(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      longint unsigned c, r, d, nx, ny, bm, be, m, e;
      fit_t f;
      c = col;
      r = row;
      d = grid;
      if (d == 0) d = 1;
      if (d > 1024) d = 1024;
      nx = q24_ratio(2 * c + 1, 2 * d);
      ny = q24_ratio((2 * r + 1) * (c + 1), 2 * d * d);
      bm = 0;
      be = 0;
      for (int s = 1; s < 128; s++) begin
        m = 2 * s + 1;
        e = dist_half(nx, m);
        if (dist_half(ny, m) > e) e = dist_half(ny, m);
        if (bm == 0 || e * bm < be * m) begin
          bm = m;
          be = e;
        end
      end
      f.scale = bm[7:0];
      f.addr = ADDR_W'((r * d + c) & 64'hF_FFFF);
      pending = {pending, f};
    endfunction

    function void check_fit(logic [M_DATA_W-1:0] data);
      fit_t f;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, data);
        errors++;
        return;
      end
      f = pending.pop_front();
      checked++;
      if (data[7:0] !== f.scale) begin
        $display("%0t scale_byte expected %0d actual %0d", $time, f.scale, data[7:0]);
        errors++;
      end
      if (data[27:8] !== f.addr) begin
        $display("%0t table_address expected %0d actual %0d", $time, f.addr, data[27:8]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [GRID_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [M_DATA_W-1:0] m_tdata;
  bit calm = 0;
  longint cycles = 0;
  int unsigned sent = 0;
  fit_board board = new();

  best_fit_normal_scale_search_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_fit(m_tdata);
  end

  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (calm) begin
        m_tready <= 1;
      end else if ($urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 18);
        m_tready <= 0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        m_tready <= 1;
      end
    end
  end

  task automatic write_grid(logic [GRID_W-1:0] g);
    cfg_we <= 1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 0;
    board.set_grid(g);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (170) @(posedge clk);
  endtask

  task automatic send_cell(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {4'b0, row, col};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_cell(col, row);
    sent++;
  endtask

  task automatic random_cells(int n);
    int unsigned d;
    for (int i = 0; i < n; i++) begin
      d = board.grid == 0 ? 1 : (board.grid > 1024 ? 1024 : board.grid);
      if ($urandom_range(0, 9) == 0) begin
        send_cell(COL_W'($urandom), ROW_W'($urandom));
      end else begin
        send_cell(COL_W'($urandom_range(0, d - 1)), ROW_W'($urandom_range(0, d - 1)));
      end
    end
    s_tvalid <= 0;
  endtask

  initial begin
    logic [GRID_W-1:0] grids[7];
    grids = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd7, 11'd1500, 11'd255};
    board.set_grid(GRID_RESET);
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_cell(10'd0, 10'd0);
    send_cell(10'd1023, 10'd1023);
    send_cell(10'd1023, 10'd0);
    send_cell(10'd0, 10'd1023);
    send_cell(10'h2AA, 10'h155);
    send_cell(10'h155, 10'h2AA);
    send_cell(10'd511, 10'd512);
    s_tvalid <= 0;
    drain();
    write_grid(11'd3);
    send_cell(10'd0, 10'd0);
    send_cell(10'd2, 10'd2);
    send_cell(10'd3, 10'd1);
    send_cell(10'd1023, 10'd1023);
    s_tvalid <= 0;
    drain();
    foreach (grids[k]) begin
      write_grid(grids[k]);
      random_cells(k == 6 ? 150 : 110);
      if (k != 6) drain();
    end
    write_grid_skip: begin end
    calm = 1;
    drain();
    random_cells(80);
    drain();
    $display("Sent %0d cells over eight grid sizes including 0, 1, 1024 and 2047.", sent);
    $display("Checked %0d results with random stalls on both channels.", board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
